// File: src/osa_pkg.sv
// ----------------------------------------------------------------------------
// osa_pkg: shared types and constants of the OSA edit distance row engine
// Field widths, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package osa_pkg;

  localparam int MAX_LEN_DEFAULT = 32;

  localparam int CHAR_W = 8;
  localparam int POS_W  = 6;
  localparam int DIST_W = 6;
  // internal cost width: one bit of headroom over a stored entry
  localparam int VAL_W  = DIST_W + 1;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_MAX_DIST     = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_LENGTH = 1'b1;

  localparam logic [DIST_W-1:0] MAX_DIST_RESET     = 6'd2;
  localparam logic [DIST_W-1:0] QUERY_LENGTH_RESET = 6'd1;
  localparam logic [VAL_W-1:0]  VAL_SAT            = 7'd63;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_q;   // store one query character
    logic latch;    // capture a row request, store its candidate character
    logic issue;    // read first column and candidate byte
    logic step;     // compute one column, read the next
    logic finish;   // load the output register
  } cmd_t;

  typedef struct packed {
    logic load_ok;
    logic row_ok;
    logic len_zero;
    logic last_col;
    logic out_free;
  } sts_t;

endpackage

// File: src/osa_ram.sv
// ----------------------------------------------------------------------------
// osa_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module osa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/osa_ctrl.sv
// ----------------------------------------------------------------------------
// osa_ctrl: sequencer of the OSA edit distance row engine
// Walks one row request through read, column steps and result hand-off.
// ----------------------------------------------------------------------------
module osa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  osa_pkg::sts_t sts,
  output osa_pkg::cmd_t cmd
);

  import osa_pkg::*;

  state_t st;
  state_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next  = st;
    cmd      = '0;
    in_stall = 1'b1;
    unique case (st)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && sts.load_ok) begin
          cmd.load_q = 1'b1;
        end
        if (in_valid && sts.row_ok) begin
          cmd.latch = 1'b1;
          st_next   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.issue = 1'b1;
        st_next   = sts.len_zero ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (sts.last_col) begin
          st_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          st_next    = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RUN && sts.last_col) |=> st == ST_DONE)
    else $error("row walk did not end at the last column");

  a_read_to_run: assert property (@(posedge clk) disable iff (rst)
    (st == ST_READ && !sts.len_zero) |=> st == ST_RUN)
    else $error("non-empty query did not start the column walk");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DONE && !sts.out_free) |=> (st == ST_DONE && !cmd.latch))
    else $error("result dropped while output register busy");

endmodule

// File: src/osa_dp.sv
// ----------------------------------------------------------------------------
// osa_dp: datapath of the OSA edit distance row engine
// Query, candidate and row memories, the column recurrence, the prune flag
// and the output register.
// ----------------------------------------------------------------------------
module osa_dp #(
  parameter int MAX_LEN = osa_pkg::MAX_LEN_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  osa_pkg::cmd_t                  cmd,
  output osa_pkg::sts_t                  sts,
  input  logic                           write_enable,
  input  logic [osa_pkg::REG_IDX_W-1:0]  register_index,
  input  logic [osa_pkg::DIST_W-1:0]     write_data,
  input  logic                           action,
  input  logic [osa_pkg::POS_W-1:0]      position,
  input  logic [osa_pkg::CHAR_W-1:0]     character,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           pruned,
  output logic [osa_pkg::DIST_W-1:0]     distance
);

  import osa_pkg::*;

  localparam int LW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 2);
  localparam int RAW = 2 * LW;

  // configuration
  logic [DIST_W-1:0] max_dist;
  logic [DIST_W-1:0] query_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist     <= MAX_DIST_RESET;
      query_length <= QUERY_LENGTH_RESET;
    end else if (write_enable) begin
      unique case (register_index)
        REG_MAX_DIST:     max_dist     <= write_data;
        REG_QUERY_LENGTH: query_length <= write_data;
        default:          max_dist     <= max_dist;
      endcase
    end
  end

  // request decode
  logic pos_ok;
  assign pos_ok = (position != '0) && ({1'b0, position} <= VAL_W'(MAX_LEN));

  // row context
  logic [POS_W-1:0]  pos_r;
  logic [CHAR_W-1:0] ch_r;
  logic [CW-1:0]     len_r;
  logic [CW-1:0]     col;
  logic [CW-1:0]     cj;
  logic              keep;
  logic [VAL_W-1:0]  left;
  logic [VAL_W-1:0]  diag;
  logic [VAL_W-1:0]  b1;
  logic [VAL_W-1:0]  b2;
  logic [CHAR_W-1:0] qprev;

  logic [CHAR_W-1:0] q_data;
  logic [CHAR_W-1:0] cprev;
  logic [DIST_W-1:0] rda_data;
  logic [DIST_W-1:0] rdb_data;

  assign cj = col - CW'(1);

  // memories
  logic [RAW-1:0] row_wr_addr;
  logic [RAW-1:0] rda_addr;
  logic [RAW-1:0] rdb_addr;
  logic [DIST_W-1:0] v_store;

  assign row_wr_addr = {LW'(pos_r - POS_W'(1)), LW'(cj - CW'(1))};
  assign rda_addr    = {LW'(pos_r - POS_W'(2)), LW'(col - CW'(1))};
  assign rdb_addr    = {LW'(pos_r - POS_W'(3)), LW'(col - CW'(1))};

  osa_ram #(.WIDTH(CHAR_W), .DEPTH(1 << LW)) u_query (
    .clk     (clk),
    .wr_en   (cmd.load_q),
    .wr_addr (LW'(position - POS_W'(1))),
    .wr_data (character),
    .rd_addr (LW'(col - CW'(1))),
    .rd_data (q_data)
  );

  osa_ram #(.WIDTH(CHAR_W), .DEPTH(1 << LW)) u_cand (
    .clk     (clk),
    .wr_en   (cmd.latch),
    .wr_addr (LW'(position - POS_W'(1))),
    .wr_data (character),
    .rd_addr (LW'(pos_r - POS_W'(2))),
    .rd_data (cprev)
  );

  // two copies of the row store: one serves the row above, one two rows up
  osa_ram #(.WIDTH(DIST_W), .DEPTH(1 << RAW)) u_row_a (
    .clk     (clk),
    .wr_en   (cmd.step),
    .wr_addr (row_wr_addr),
    .wr_data (v_store),
    .rd_addr (rda_addr),
    .rd_data (rda_data)
  );

  osa_ram #(.WIDTH(DIST_W), .DEPTH(1 << RAW)) u_row_b (
    .clk     (clk),
    .wr_en   (cmd.step),
    .wr_addr (row_wr_addr),
    .wr_data (v_store),
    .rd_addr (rdb_addr),
    .rd_data (rdb_data)
  );

  // column recurrence
  logic [VAL_W-1:0] up;
  logic [VAL_W-1:0] bcur;
  logic [VAL_W-1:0] v0;
  logic [VAL_W-1:0] v1;
  logic [VAL_W-1:0] v2;
  logic [VAL_W-1:0] vs;
  logic [VAL_W-1:0] t_up;
  logic [VAL_W-1:0] t_left;
  logic [VAL_W-1:0] t_diag;
  logic [VAL_W-1:0] t_trans;
  logic             cost;
  logic             trans;

  always_comb begin
    up      = (pos_r == POS_W'(1)) ? VAL_W'(cj) : {1'b0, rda_data};
    bcur    = (pos_r == POS_W'(2)) ? VAL_W'(cj) : {1'b0, rdb_data};
    cost    = (ch_r != q_data);
    t_up    = up + VAL_W'(1);
    t_left  = left + VAL_W'(1);
    t_diag  = diag + VAL_W'(cost);
    t_trans = b2 + VAL_W'(1);
    v0      = (t_up < t_left) ? t_up : t_left;
    v1      = (t_diag < v0) ? t_diag : v0;
    trans   = (pos_r > POS_W'(1)) && (cj >= CW'(2)) &&
              (ch_r == qprev) && (cprev == q_data);
    v2      = (trans && (t_trans < v1)) ? t_trans : v1;
    vs      = (v2 > VAL_SAT) ? VAL_SAT : v2;
    v_store = vs[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pos_r <= position;
      ch_r  <= character;
      len_r <= ({1'b0, query_length} > VAL_W'(MAX_LEN)) ? CW'(MAX_LEN)
                                                          : CW'(query_length);
      col   <= CW'(1);
      keep  <= 1'b0;
      left  <= VAL_W'(position);
      diag  <= VAL_W'(position - POS_W'(1));
      b1    <= VAL_W'(position - POS_W'(2));
    end else if (cmd.issue) begin
      col <= col + CW'(1);
    end else if (cmd.step) begin
      col   <= col + CW'(1);
      left  <= vs;
      diag  <= up;
      qprev <= q_data;
      b2    <= b1;
      b1    <= bcur;
      if (vs <= VAL_W'(max_dist)) begin
        keep <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pruned   <= ~keep;
      distance <= left[DIST_W-1:0];
    end
  end

  always_comb begin
    sts          = '0;
    sts.load_ok  = ~action & pos_ok;
    sts.row_ok   = action & pos_ok;
    sts.len_zero = (len_r == '0);
    sts.last_col = (cj == len_r);
    sts.out_free = ~out_valid | ~out_stall;
  end

endmodule

// File: src/osa_edit_distance_row_engine.sv
// ----------------------------------------------------------------------------
// osa_edit_distance_row_engine: incremental OSA edit distance, one row a request
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// A load request (action 0) stores one query byte at column "position".
// A row request (action 1) stores the candidate byte at depth "position" and
// computes that row of the restricted Damerau matrix from the two rows
// stored above it, one column per cycle through the row memories. A row
// request occupies the block from capture through the first read and the
// column steps to the result hand-off, with query_length limited to MAX_LEN;
// the hand-off waits while the output register is busy. The result (distance
// in the last query column, and pruned when no column is within max_dist)
// waits in an output register. Requests with position 0 or above MAX_LEN are
// taken and dropped without a result. Rows must be computed in trie order: a
// row reads the two rows above it, so those must have been written. Write
// configuration only while idle.
// ----------------------------------------------------------------------------
module osa_edit_distance_row_engine #(
  parameter int MAX_LEN = osa_pkg::MAX_LEN_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [osa_pkg::REG_IDX_W-1:0] register_index,
  input  logic [osa_pkg::DIST_W-1:0]    write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [osa_pkg::POS_W-1:0]     position,
  input  logic [osa_pkg::CHAR_W-1:0]    character,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          pruned,
  output logic [osa_pkg::DIST_W-1:0]    distance
);

  import osa_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: accept requests, step columns, hand off the result
  osa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: memories, recurrence, prune tracking, output register
  osa_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .action         (action),
    .position       (position),
    .character      (character),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pruned         (pruned),
    .distance       (distance)
  );

endmodule

// File: sim/tb_osa_edit_distance_row_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_osa_edit_distance_row_engine: self-checking bench for the OSA row engine
// Walks a short script of corner requests, then random trie walks over random
// query words and settings. Every valid row request is predicted, from the
// script's values where given, else by an in-bench copy of the row
// recurrence; each returned result is compared field by field with the oldest.
// ----------------------------------------------------------------------------
module tb_osa_edit_distance_row_engine;
  import osa_pkg::*;

  localparam int MAX_LEN       = MAX_LEN_DEFAULT;
  // a row request holds the block through its column walk; leave margin
  localparam int SETTLE_CYCLES = MAX_LEN + 8;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEM_TARGET   = 1100;

  localparam bit STEP_REQUEST = 1'b0;
  localparam bit STEP_WRITE   = 1'b1;

  typedef enum bit {
    ACT_LOAD = 1'b0,
    ACT_ROW  = 1'b1
  } req_action_t;

  typedef struct packed {
    bit                    kind;
    bit                    act;
    logic [REG_IDX_W-1:0]  reg_sel;
    logic [POS_W-1:0]      pos;
    logic [CHAR_W-1:0]     data;
    bit                    typed;
    bit                    exp_pruned;
    logic [DIST_W-1:0]     exp_dist;
  } opening_step_t;

  typedef struct {
    bit                 pruned;
    logic [DIST_W-1:0]  distance;
  } row_result_t;

  logic                  clk;
  logic                  rst;
  logic                  write_enable;
  logic [REG_IDX_W-1:0]  register_index;
  logic [DIST_W-1:0]     write_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  action;
  logic [POS_W-1:0]      position;
  logic [CHAR_W-1:0]     character;
  logic                  out_valid;
  logic                  out_stall;
  logic                  pruned;
  logic [DIST_W-1:0]     distance;

  osa_edit_distance_row_engine #(.MAX_LEN(MAX_LEN)) dut (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .position       (position),
    .character      (character),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pruned         (pruned),
    .distance       (distance)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Opening script: reset settings first, then dropped positions, the empty
  // query, a swapped pair of letters, and the extreme settings.
  opening_step_t opening_steps [0:23] = '{
    '{STEP_REQUEST, ACT_LOAD, REG_MAX_DIST,     6'd1,  8'h00, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd1,  8'h00, 1'b1, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd2,  8'hFF, 1'b1, 1'b0, 6'd1},
    '{STEP_REQUEST, ACT_LOAD, REG_MAX_DIST,     6'd0,  8'hAA, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd0,  8'hAA, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd33, 8'h11, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_LOAD, REG_MAX_DIST,     6'd63, 8'h22, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd63, 8'hFF, 1'b0, 1'b0, 6'd0},
    '{STEP_WRITE,   ACT_LOAD, REG_MAX_DIST,     6'd0,  8'd0,  1'b0, 1'b0, 6'd0},
    '{STEP_WRITE,   ACT_LOAD, REG_QUERY_LENGTH, 6'd0,  8'd0,  1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd3,  8'h55, 1'b1, 1'b1, 6'd3},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd32, 8'h80, 1'b1, 1'b1, 6'd32},
    '{STEP_WRITE,   ACT_LOAD, REG_MAX_DIST,     6'd0,  8'd1,  1'b0, 1'b0, 6'd0},
    '{STEP_WRITE,   ACT_LOAD, REG_QUERY_LENGTH, 6'd0,  8'd2,  1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_LOAD, REG_MAX_DIST,     6'd1,  8'h61, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_LOAD, REG_MAX_DIST,     6'd2,  8'h62, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd1,  8'h62, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd2,  8'h61, 1'b0, 1'b0, 6'd0},
    '{STEP_WRITE,   ACT_LOAD, REG_MAX_DIST,     6'd0,  8'd32, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd1,  8'h61, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd2,  8'h62, 1'b0, 1'b0, 6'd0},
    '{STEP_WRITE,   ACT_LOAD, REG_MAX_DIST,     6'd0,  8'd63, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_ROW,  REG_MAX_DIST,     6'd2,  8'h7F, 1'b0, 1'b0, 6'd0},
    '{STEP_REQUEST, ACT_LOAD, REG_MAX_DIST,     6'd32, 8'hC3, 1'b0, 1'b0, 6'd0}
  };

  // Shadow of the block: query and candidate bytes, the row matrix, the two
  // settings, and a written flag for every entry so that no request ever
  // makes the block read a never-written location.
  logic [CHAR_W-1:0] query_bytes [MAX_LEN];
  logic [CHAR_W-1:0] cand_bytes  [MAX_LEN];
  logic [DIST_W-1:0] row_mem     [MAX_LEN][MAX_LEN];
  bit                query_known [MAX_LEN];
  bit                cand_known  [MAX_LEN];
  bit                row_known   [MAX_LEN][MAX_LEN];
  logic [DIST_W-1:0] keep_limit;
  logic [DIST_W-1:0] query_len;

  row_result_t pending_rows[$];

  int  failures;
  int  items_sent;
  int  results_seen;
  bit  calm;

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic int lesser(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int active_len();
    return (query_len > MAX_LEN) ? MAX_LEN : int'(query_len);
  endfunction

  // Matrix entry with the implicit top row (j) and left column (i).
  function automatic int matrix_at(input int r, input int c);
    if (c == 0) begin
      return r;
    end
    if (r == 0) begin
      return c;
    end
    return int'(row_mem[r-1][c-1]);
  endfunction

  // Compute one OSA row at depth p for candidate byte ch and store it.
  function automatic void osa_row(input int p, input logic [CHAR_W-1:0] ch,
                                  output row_result_t res);
    int  len2;
    int  j;
    int  v;
    int  cost;
    bit  keep;
    len2 = active_len();
    keep = 1'b0;
    cand_bytes[p-1] = ch;
    cand_known[p-1] = 1'b1;
    for (j = 1; j <= len2; j++) begin
      cost = (ch == query_bytes[j-1]) ? 0 : 1;
      v = lesser(matrix_at(p - 1, j) + 1, matrix_at(p, j - 1) + 1);
      v = lesser(v, matrix_at(p - 1, j - 1) + cost);
      // adjacent swap: candidate ends in the query's pair j-1, j reversed
      if (p > 1 && j >= 2 && ch == query_bytes[j-2] &&
          cand_bytes[p-2] == query_bytes[j-1]) begin
        v = lesser(v, matrix_at(p - 2, j - 2) + 1);
      end
      if (v > 63) begin
        v = 63;
      end
      row_mem[p-1][j-1] = v[DIST_W-1:0];
      row_known[p-1][j-1] = 1'b1;
      if (v <= keep_limit) begin
        keep = 1'b1;
      end
    end
    v = matrix_at(p, len2);
    if (v > 63) begin
      v = 63;
    end
    res.pruned = !keep;
    res.distance = v[DIST_W-1:0];
  endfunction

  // True when a row request at depth p reads only entries already written.
  function automatic bit row_reads_written(input int p);
    int len2;
    int j;
    len2 = active_len();
    for (j = 1; j <= len2; j++) begin
      if (!query_known[j-1]) begin
        return 1'b0;
      end
      if (p > 1 && (!row_known[p-2][j-1] || !cand_known[p-2])) begin
        return 1'b0;
      end
      if (p > 2 && j <= len2 - 2 && !row_known[p-3][j-1]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Offer one request, hold it until taken, then update the shadow state.
  task automatic offer(input req_action_t act, input int pos,
                       input logic [CHAR_W-1:0] ch, input bit typed,
                       input bit exp_pruned, input logic [DIST_W-1:0] exp_dist);
    row_result_t res;
    if (!calm) begin
      while ($urandom_range(0, 99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    action    <= act;
    position  <= pos[POS_W-1:0];
    character <= ch;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    // positions outside 1..MAX_LEN are swallowed without a result
    if (pos >= 1 && pos <= MAX_LEN) begin
      items_sent++;
      if (act == ACT_LOAD) begin
        query_bytes[pos-1] = ch;
        query_known[pos-1] = 1'b1;
      end else begin
        osa_row(pos, ch, res);
        if (typed) begin
          res.pruned = exp_pruned;
          res.distance = exp_dist;
        end
        pending_rows.push_back(res);
      end
    end
    calm <= (items_sent >= 400 && items_sent < 600);
  endtask

  // Drain the block, let in-flight loads settle, then write one register.
  task automatic write_setting(input logic [REG_IDX_W-1:0] idx, input int val);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= val[DIST_W-1:0];
    @(posedge clk);
    write_enable   <= 1'b0;
    if (idx == REG_MAX_DIST) begin
      keep_limit = val[DIST_W-1:0];
    end else begin
      query_len = val[DIST_W-1:0];
    end
  endtask

  // Candidate byte, usually the query's byte at or next to this depth so that
  // matches and swapped pairs turn up often.
  function automatic logic [CHAR_W-1:0] pick_char(input int p,
                                                  input logic [CHAR_W-1:0] alpha [4]);
    int r;
    int col;
    int len2;
    len2 = active_len();
    r = $urandom_range(0, 99);
    if (len2 > 0 && r < 60) begin
      col = p + $urandom_range(0, 2) - 1;
      if (col < 1) begin
        col = 1;
      end
      if (col > len2) begin
        col = len2;
      end
      return query_bytes[col-1];
    end
    if (r < 85) begin
      return alpha[$urandom_range(0, 3)];
    end
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // One word session: settings, query load in shuffled order, then a trie
  // walk with occasional backtracking, out-of-order rows, query edits and
  // dropped positions. A negative argument picks that setting at random.
  task automatic run_session(input int len_sel, input int dist_sel);
    int                len_reg;
    int                dist_reg;
    int                eff;
    int                depth;
    int                steps;
    int                s;
    int                r;
    int                p;
    int                k;
    int                tmp;
    int                lim;
    int                order [MAX_LEN];
    logic [CHAR_W-1:0] alpha [4];
    logic [CHAR_W-1:0] qc;
    len_reg = len_sel;
    if (len_reg < 0) begin
      r = $urandom_range(0, 99);
      if (r < 70) len_reg = $urandom_range(1, 8);
      else if (r < 85) len_reg = $urandom_range(9, 31);
      else if (r < 92) len_reg = MAX_LEN;
      else if (r < 96) len_reg = $urandom_range(MAX_LEN + 1, 63);
      else len_reg = 0;
    end
    dist_reg = dist_sel;
    if (dist_reg < 0) begin
      r = $urandom_range(0, 99);
      if (r < 20) dist_reg = 0;
      else if (r < 30) dist_reg = 32;
      else if (r < 35) dist_reg = 63;
      else dist_reg = $urandom_range(1, 6);
    end
    write_setting(REG_QUERY_LENGTH, len_reg);
    write_setting(REG_MAX_DIST, dist_reg);
    eff = active_len();
    for (k = 0; k < 4; k++) begin
      alpha[k] = CHAR_W'($urandom_range(0, 255));
    end
    for (k = 0; k < eff; k++) begin
      order[k] = k + 1;
    end
    for (k = eff - 1; k > 0; k--) begin
      r = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[r];
      order[r] = tmp;
    end
    for (k = 0; k < eff; k++) begin
      qc = ($urandom_range(0, 9) != 0) ? alpha[$urandom_range(0, 3)]
                                       : CHAR_W'($urandom_range(0, 255));
      offer(ACT_LOAD, order[k], qc, 1'b0, 1'b0, '0);
    end
    // long queries make every row slow: keep those walks short
    steps = (eff <= 8) ? $urandom_range(8, 40) : $urandom_range(3, 10);
    depth = 0;
    for (s = 0; s < steps; s++) begin
      r = $urandom_range(0, 99);
      lim = (depth < MAX_LEN) ? depth + 1 : MAX_LEN;
      if (r < 6) begin
        p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_LEN + 1, 63);
        offer(req_action_t'($urandom_range(0, 1)), p,
              CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end else if (r < 11) begin
        p = (eff > 0) ? $urandom_range(1, eff) : $urandom_range(1, MAX_LEN);
        offer(ACT_LOAD, p, alpha[$urandom_range(0, 3)], 1'b0, 1'b0, '0);
      end else if (r < 18) begin
        // out-of-order row; fall back to the next trie row if it would
        // read something never written
        p = $urandom_range(1, MAX_LEN);
        if (!row_reads_written(p)) begin
          p = lim;
        end
        offer(ACT_ROW, p, pick_char(p, alpha), 1'b0, 1'b0, '0);
      end else begin
        p = ($urandom_range(0, 99) < 65) ? lim : $urandom_range(1, lim);
        depth = p;
        offer(ACT_ROW, p, pick_char(p, alpha), 1'b0, 1'b0, '0);
      end
    end
  endtask

  // Result side: check at every taken result, stall at random, and once
  // hold off for a long stretch while requests keep arriving.
  initial begin : result_side
    int          hold_left;
    bit          hold_done;
    row_result_t want;
    failures     = 0;
    results_seen = 0;
    out_stall    = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        results_seen++;
        if (pending_rows.size() == 0) begin
          note_failure($sformatf("unexpected result pruned=%b distance=%0d",
                                 pruned, distance));
        end else begin
          want = pending_rows.pop_front();
          if (pruned !== want.pruned) begin
            note_failure($sformatf("pruned mismatch: expected %b got %b",
                                   want.pruned, pruned));
          end
          if (distance !== want.distance) begin
            note_failure($sformatf("distance mismatch: expected %0d got %0d",
                                   want.distance, distance));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 200 && in_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 8);
      end
    end
  end

  // Watchdog: end the run if neither side moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL osa_edit_distance_row_engine");
    $finish;
  end

  initial begin : request_side
    int i;
    items_sent     = 0;
    calm           = 1'b0;
    rst            = 1'b1;
    write_enable   = 1'b0;
    register_index = '0;
    write_data     = '0;
    in_valid       = 1'b0;
    action         = 1'b0;
    position       = '0;
    character      = '0;
    keep_limit     = MAX_DIST_RESET;
    query_len      = QUERY_LENGTH_RESET;
    for (i = 0; i < MAX_LEN; i++) begin
      query_known[i] = 1'b0;
      cand_known[i]  = 1'b0;
      for (int c = 0; c < MAX_LEN; c++) begin
        row_known[i][c] = 1'b0;
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // walk the opening script
    for (i = 0; i < $size(opening_steps); i++) begin
      if (opening_steps[i].kind == STEP_WRITE) begin
        write_setting(opening_steps[i].reg_sel, int'(opening_steps[i].data));
      end else begin
        offer(req_action_t'(opening_steps[i].act), int'(opening_steps[i].pos),
              opening_steps[i].data, opening_steps[i].typed,
              opening_steps[i].exp_pruned, opening_steps[i].exp_dist);
      end
    end

    // first session exercises query_length saturation, then random sessions
    run_session(63, 5);
    while (items_sent < ITEM_TARGET) begin
      run_session(-1, -1);
    end

    in_valid <= 1'b0;
    while (pending_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("PASS osa_edit_distance_row_engine");
    end else begin
      $display("FAIL osa_edit_distance_row_engine");
    end
    $finish;
  end

endmodule
